### hdl/cra_pkg.sv
// Shared constants for the contiguous run allocator: field widths,
// word layout and result status codes. No dependencies.
package cra_pkg;

   localparam int ZONE_W      = 2;
   localparam int COUNT_W     = 5;
   localparam int OWNER_IN_W  = 16;
   localparam int OWNER_MAX_W = 32;
   localparam int SEAT_W      = 7;
   localparam int STATUS_W    = 2;
   localparam int FREE_OUT_W  = 8;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;

   // Reciprocal shift for dividing a seat number by the row length.
   localparam int DIV_SHIFT   = 2 * SEAT_W;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FEW   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NORUN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

   localparam logic [ZONE_W-1:0] ZONE_A = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_B = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_C = 2'd2;

   localparam logic ACT_RESERVE = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

endpackage

### hdl/cra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cra_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cra_run_find.sv
// First-fit run detector over one row of slots: finds the lowest start of
// a run of the requested length of free slots. Uses cra_pkg.
module cra_run_find #(
   parameter int SLOTS = 16
) (
   input  logic [SLOTS-1:0]                  free_bits,
   input  logic [cra_pkg::COUNT_W-1:0]       count,
   output logic                              found,
   output logic [$clog2(SLOTS)-1:0]          start
);

   import cra_pkg::*;

   localparam int CW = $clog2(SLOTS);

   logic [SLOTS-1:0] len_mask;
   logic [SLOTS-1:0] window;

   always_comb begin
      for (int j = 0; j < SLOTS; j++) begin
         len_mask[j] = (j < int'(count));
      end
   end

   // Walk from the top so the lowest fitting start wins.
   always_comb begin
      found  = 1'b0;
      start  = '0;
      window = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         window = len_mask << s;
         if ((s + int'(count) <= SLOTS) && ((window & ~free_bits) == '0)) begin
            found = 1'b1;
            start = CW'(s);
         end
      end
   end

endmodule

### hdl/contiguous_run_allocator_core.sv
// Top level of the contiguous run allocator: sequencer, free counters,
// row valid bits and result register. Uses cra_pkg, cra_ram, cra_run_find.
//
//  channel | ports                       | role
//  --------+-----------------------------+-----------------------------------
//  req     | req_tvalid/tready/tdata/user| reserve or release request word
//  rsp     | rsp_tvalid/tready/tdata     | one result word per request
//
// Steps: reserve = check, then read + evaluate per row scanned; release = check, divide, column,
// range check, read, evaluate; a failed check ends at check, an out-of-row/zone release at range check.
// Reset: synchronous; owner rows read as empty through per-row valid bits,
// so no clearing pass is needed. Free counters return to zone capacity.
// Stalls: a request is taken while a result waits; the next result holds
// in its final step until the pending one is taken.
module contiguous_run_allocator_core #(
   parameter int SLOTS_PER_ROW = 16,
   parameter int ROWS_ZONE_A   = 8,
   parameter int ROWS_ZONE_B   = 8,
   parameter int ROWS_ZONE_C   = 8,
   parameter int OWNER_WIDTH   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // zone[1:0], seat_count[6:2], owner_id[22:7], first_seat[29:23]
   input  logic [cra_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status[1:0], start_seat[8:2], free_after[16:9]
   output logic [cra_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   import cra_pkg::*;

   localparam int CAP_A      = ROWS_ZONE_A * SLOTS_PER_ROW;
   localparam int CAP_B      = ROWS_ZONE_B * SLOTS_PER_ROW;
   localparam int CAP_C      = ROWS_ZONE_C * SLOTS_PER_ROW;
   localparam int CAP_AB     = (CAP_A > CAP_B) ? CAP_A : CAP_B;
   localparam int CAP_MAX    = (CAP_AB > CAP_C) ? CAP_AB : CAP_C;
   localparam int ROWS_AB    = (ROWS_ZONE_A > ROWS_ZONE_B) ? ROWS_ZONE_A : ROWS_ZONE_B;
   localparam int ROWS_MAX   = (ROWS_AB > ROWS_ZONE_C) ? ROWS_AB : ROWS_ZONE_C;
   localparam int TOTAL_ROWS = ROWS_ZONE_A + ROWS_ZONE_B + ROWS_ZONE_C;
   localparam int AW         = $clog2(TOTAL_ROWS);
   localparam int FW         = $clog2(CAP_MAX + 1);
   localparam int SB_W       = $clog2(CAP_MAX);
   localparam int CW         = $clog2(SLOTS_PER_ROW);
   localparam int ROW_SCAN_W = $clog2(ROWS_MAX) > 0 ? $clog2(ROWS_MAX) : 1;
   localparam int ROW_DIV_W  = $clog2((2**SEAT_W - 1) / SLOTS_PER_ROW + 1) > 0 ?
                               $clog2((2**SEAT_W - 1) / SLOTS_PER_ROW + 1) : 1;
   localparam int ROW_W      = (ROW_SCAN_W > ROW_DIV_W) ? ROW_SCAN_W : ROW_DIV_W;
   localparam int RWID       = SLOTS_PER_ROW * OWNER_WIDTH;
   localparam int PROD_W     = SEAT_W + DIV_SHIFT;
   localparam logic [DIV_SHIFT-1:0] RECIP =
      DIV_SHIFT'((2**DIV_SHIFT + SLOTS_PER_ROW - 1) / SLOTS_PER_ROW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_COL   = 3'd3;
   localparam logic [2:0] S_RCHK  = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_EVAL  = 3'd6;

   function automatic int zone_rows(input logic [ZONE_W-1:0] z);
      int r;
      case (z)
         ZONE_A:  r = ROWS_ZONE_A;
         ZONE_B:  r = ROWS_ZONE_B;
         default: r = ROWS_ZONE_C;
      endcase
      return r;
   endfunction

   function automatic int zone_base(input logic [ZONE_W-1:0] z);
      int b;
      case (z)
         ZONE_A:  b = 0;
         ZONE_B:  b = ROWS_ZONE_A;
         default: b = ROWS_ZONE_A + ROWS_ZONE_B;
      endcase
      return b;
   endfunction

   // Control state
   logic [2:0]            state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]         free_ff [3];
   logic [FW-1:0]         free_in [3];
   logic [TOTAL_ROWS-1:0] row_valid_ff, row_valid_in;

   // Request and working payload
   logic                      action_ff;
   logic [ZONE_W-1:0]         zone_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [OWNER_WIDTH-1:0]    owner_ff;
   logic [SEAT_W-1:0]         first_ff;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [SB_W-1:0]           seat_base_ff, seat_base_in;
   logic [SEAT_W-1:0]         col_ff, col_in;

   // Result payload
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [SEAT_W-1:0]         rsp_start_ff, rsp_start_in;
   logic [FREE_OUT_W-1:0]     rsp_free_ff, rsp_free_in;

   logic                      accept;
   logic                      out_free;
   logic [OWNER_MAX_W-1:0]    owner_wide;
   logic                      zone_ok;
   logic [FW-1:0]             cur_free;
   logic [FW-1:0]             cur_cap;
   logic [FW:0]               rel_sum;
   logic [FW-1:0]             rel_free;
   logic [FW-1:0]             res_free;
   logic [PROD_W-1:0]         div_prod;
   logic [AW-1:0]             row_addr;
   logic                      rd_en;
   logic                      wr_en;
   logic [RWID-1:0]           rd_data;
   logic [RWID-1:0]           row_cur;
   logic [RWID-1:0]           row_new;
   logic [SLOTS_PER_ROW-1:0]  free_bits;
   logic                      find_found;
   logic [CW-1:0]             find_start;
   logic [CW-1:0]             win_start;
   logic [OWNER_WIDTH-1:0]    fill;
   logic                      last_row;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign owner_wide = {{(OWNER_MAX_W - OWNER_IN_W){1'b0}}, req_tdata[22:7]};

   assign zone_ok = (zone_ff == ZONE_A) || (zone_ff == ZONE_B) || (zone_ff == ZONE_C);

   always_comb begin
      case (zone_ff)
         ZONE_A:  begin cur_free = free_ff[0]; cur_cap = FW'(CAP_A); end
         ZONE_B:  begin cur_free = free_ff[1]; cur_cap = FW'(CAP_B); end
         ZONE_C:  begin cur_free = free_ff[2]; cur_cap = FW'(CAP_C); end
         default: begin cur_free = '0;         cur_cap = '0;         end
      endcase
   end

   assign rel_sum  = {1'b0, cur_free} + (FW + 1)'(count_ff);
   assign rel_free = (rel_sum > {1'b0, cur_cap}) ? cur_cap : rel_sum[FW-1:0];
   assign res_free = cur_free - FW'(count_ff);

   assign div_prod = PROD_W'(first_ff) * PROD_W'(RECIP);
   assign row_addr = AW'(zone_base(zone_ff) + int'(row_ff));
   assign last_row = (int'(row_ff) == zone_rows(zone_ff) - 1);

   cra_ram #(
      .WIDTH (RWID),
      .DEPTH (TOTAL_ROWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_addr),
      .wr_data (row_new),
      .rd_en   (rd_en),
      .rd_addr (row_addr),
      .rd_data (rd_data)
   );

   // A row never written reads as all free.
   assign row_cur = row_valid_ff[row_addr] ? rd_data : '0;

   always_comb begin
      for (int i = 0; i < SLOTS_PER_ROW; i++) begin
         free_bits[i] = (row_cur[i*OWNER_WIDTH +: OWNER_WIDTH] == '0);
      end
   end

   cra_run_find #(
      .SLOTS (SLOTS_PER_ROW)
   ) u_find (
      .free_bits (free_bits),
      .count     (count_ff),
      .found     (find_found),
      .start     (find_start)
   );

   assign win_start = (action_ff == ACT_RELEASE) ? CW'(col_ff) : find_start;
   assign fill      = (action_ff == ACT_RELEASE) ? '0 : owner_ff;

   always_comb begin
      for (int i = 0; i < SLOTS_PER_ROW; i++) begin
         if ((i >= int'(win_start)) && (i < int'(win_start) + int'(count_ff))) begin
            row_new[i*OWNER_WIDTH +: OWNER_WIDTH] = fill;
         end else begin
            row_new[i*OWNER_WIDTH +: OWNER_WIDTH] = row_cur[i*OWNER_WIDTH +: OWNER_WIDTH];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      free_in       = free_ff;
      row_valid_in  = row_valid_ff;
      row_in        = row_ff;
      seat_base_in  = seat_base_ff;
      col_in        = col_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!zone_ok || (count_ff == '0) ||
                ((action_ff == ACT_RESERVE) && (owner_ff == '0))) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD;
                  rsp_start_in  = '0;
                  rsp_free_in   = zone_ok ? FREE_OUT_W'(cur_free) : '0;
                  state_in      = S_IDLE;
               end
            end else if (action_ff == ACT_RESERVE) begin
               if (int'(cur_free) < int'(count_ff)) begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FEW;
                     rsp_start_in  = '0;
                     rsp_free_in   = FREE_OUT_W'(cur_free);
                     state_in      = S_IDLE;
                  end
               end else begin
                  row_in       = '0;
                  seat_base_in = '0;
                  state_in     = S_READ;
               end
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            row_in   = ROW_W'(div_prod >> DIV_SHIFT);
            state_in = S_COL;
         end
         S_COL: begin
            col_in   = first_ff - SEAT_W'(int'(row_ff) * SLOTS_PER_ROW);
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if ((int'(first_ff) + int'(count_ff) > int'(cur_cap)) ||
                (int'(col_ff) + int'(count_ff) > SLOTS_PER_ROW)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_BAD;
                  rsp_start_in  = '0;
                  rsp_free_in   = FREE_OUT_W'(cur_free);
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (action_ff == ACT_RELEASE) begin
               if (out_free) begin
                  wr_en                  = 1'b1;
                  row_valid_in[row_addr] = 1'b1;
                  free_in[zone_ff]       = rel_free;
                  rsp_valid_in           = 1'b1;
                  rsp_status_in          = ST_DONE;
                  rsp_start_in           = '0;
                  rsp_free_in            = FREE_OUT_W'(rel_free);
                  state_in               = S_IDLE;
               end
            end else if (find_found) begin
               if (out_free) begin
                  wr_en                  = 1'b1;
                  row_valid_in[row_addr] = 1'b1;
                  free_in[zone_ff]       = res_free;
                  rsp_valid_in           = 1'b1;
                  rsp_status_in          = ST_DONE;
                  rsp_start_in           = SEAT_W'(int'(seat_base_ff) + int'(find_start));
                  rsp_free_in            = FREE_OUT_W'(res_free);
                  state_in               = S_IDLE;
               end
            end else if (last_row) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NORUN;
                  rsp_start_in  = '0;
                  rsp_free_in   = FREE_OUT_W'(cur_free);
                  state_in      = S_IDLE;
               end
            end else begin
               // advance to the next row of the zone
               row_in       = row_ff + 1'b1;
               seat_base_in = seat_base_ff + SB_W'(SLOTS_PER_ROW);
               state_in     = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_ff[0]   <= FW'(CAP_A);
         free_ff[1]   <= FW'(CAP_B);
         free_ff[2]   <= FW'(CAP_C);
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_ff      <= free_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_tuser;
         zone_ff   <= req_tdata[1:0];
         count_ff  <= req_tdata[6:2];
         owner_ff  <= owner_wide[OWNER_WIDTH-1:0];
         first_ff  <= req_tdata[29:23];
      end
      row_ff        <= row_in;
      seat_base_ff  <= seat_base_in;
      col_ff        <= col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - STATUS_W - SEAT_W - FREE_OUT_W){1'b0}},
                        rsp_free_ff, rsp_start_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CHECK)
      else $error("accepted request did not enter the check step");

   a_write_gives_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff && (rsp_status_ff == ST_DONE))
      else $error("row write not followed by a done result");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> state_ff == S_EVAL)
      else $error("row read not followed by evaluation");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(free_ff[0]) <= CAP_A) && (int'(free_ff[1]) <= CAP_B) &&
      (int'(free_ff[2]) <= CAP_C))
      else $error("free count above zone capacity");
`endif

endmodule

### tb/tb.sv
// Testbench for contiguous_run_allocator_core: runs a table of directed requests and then
// random requests; each result word is checked against the table or its own seat-map predictor.
// Depends on cra_pkg and on the RTL under hdl/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cra_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int SLOTS          = 16;
   localparam int ROWS_A         = 8;
   localparam int ROWS_B         = 8;
   localparam int ROWS_C         = 8;
   localparam int RANDOM_ITEMS   = 600;
   localparam int IDLE_PCT       = 34;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int N_DIRECTED     = 26;

   localparam logic [ZONE_W-1:0] ZONE_NONE = 2'd3;

   typedef struct packed {
      logic                  action;
      logic [ZONE_W-1:0]     zone;
      logic [COUNT_W-1:0]    seat_count;
      logic [OWNER_IN_W-1:0] owner_id;
      logic [SEAT_W-1:0]     first_seat;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [SEAT_W-1:0]     start_seat;
      logic [FREE_OUT_W-1:0] free_after;
   } result_type;

   typedef struct {
      request_type req;
      bit          typed;
      result_type  want;
   } script_row_type;

   typedef struct {
      logic [ZONE_W-1:0]  zone;
      logic [SEAT_W-1:0]  start;
      logic [COUNT_W-1:0] count;
   } held_run_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // seat map and free counters of the predictor
   logic [OWNER_IN_W-1:0] seat_owner [3][ROWS_A*SLOTS];
   int unsigned           seats_free [3];

   result_type     expected_results [$];
   held_run_type   held_runs [$];
   int             mismatches = 0;
   int             results_seen = 0;
   int             req_idle_pct = IDLE_PCT;
   int             rsp_idle_pct = IDLE_PCT;
   int             quiet_cycles = 0;

   script_row_type script [N_DIRECTED] = '{
      // invalid zone, both actions
      '{'{ACT_RESERVE, ZONE_NONE, 5'd4,  16'h0001, 7'd0},   1'b1, '{ST_BAD,   7'd0, 8'd0}},
      '{'{ACT_RELEASE, ZONE_NONE, 5'd31, 16'h0000, 7'd127}, 1'b1, '{ST_BAD,   7'd0, 8'd0}},
      // zero length on both actions, zero owner on reserve
      '{'{ACT_RESERVE, ZONE_A,    5'd0,  16'h0005, 7'd0},   1'b1, '{ST_BAD,   7'd0, 8'd128}},
      '{'{ACT_RELEASE, ZONE_A,    5'd0,  16'h0000, 7'd0},   1'b1, '{ST_BAD,   7'd0, 8'd128}},
      '{'{ACT_RESERVE, ZONE_A,    5'd3,  16'h0000, 7'd0},   1'b1, '{ST_BAD,   7'd0, 8'd128}},
      // run longer than a row
      '{'{ACT_RESERVE, ZONE_A,    5'd17, 16'h1234, 7'd127}, 1'b1, '{ST_NORUN, 7'd0, 8'd128}},
      '{'{ACT_RESERVE, ZONE_A,    5'd16, 16'hFFFF, 7'd0},   1'b1, '{ST_DONE,  7'd0, 8'd112}},
      '{'{ACT_RESERVE, ZONE_A,    5'd1,  16'h0001, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_A,    5'd15, 16'h8000, 7'd0},   1'b0, '0},
      // release of a seat that is already free
      '{'{ACT_RELEASE, ZONE_A,    5'd1,  16'h0000, 7'd127}, 1'b0, '0},
      // release across a row end
      '{'{ACT_RELEASE, ZONE_A,    5'd16, 16'h0000, 7'd120}, 1'b0, '0},
      // release past the end of the zone
      '{'{ACT_RELEASE, ZONE_C,    5'd2,  16'h0000, 7'd127}, 1'b1, '{ST_BAD,   7'd0, 8'd128}},
      // release on an empty zone saturates at capacity
      '{'{ACT_RELEASE, ZONE_B,    5'd16, 16'h0000, 7'd0},   1'b1, '{ST_DONE,  7'd0, 8'd128}},
      // fill zone B, then starve it
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h0011, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h0022, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h0044, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h0088, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h0F00, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h7000, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'h4321, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd16, 16'hBEEF, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd1,  16'h0009, 7'd0},   1'b0, '0},
      // punch two gaps of four, then ask for five and for four
      '{'{ACT_RELEASE, ZONE_B,    5'd4,  16'h0000, 7'd50},  1'b0, '0},
      '{'{ACT_RELEASE, ZONE_B,    5'd4,  16'h0000, 7'd88},  1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd5,  16'h0007, 7'd0},   1'b0, '0},
      '{'{ACT_RESERVE, ZONE_B,    5'd4,  16'hAAAA, 7'd0},   1'b0, '0}
   };

   contiguous_run_allocator_core #(
      .SLOTS_PER_ROW (SLOTS),
      .ROWS_ZONE_A   (ROWS_A),
      .ROWS_ZONE_B   (ROWS_B),
      .ROWS_ZONE_C   (ROWS_C),
      .OWNER_WIDTH   (OWNER_IN_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   function automatic int unsigned zone_rows(input logic [ZONE_W-1:0] zone);
      case (zone)
         ZONE_A:  return ROWS_A;
         ZONE_B:  return ROWS_B;
         default: return ROWS_C;
      endcase
   endfunction

   // Apply one request to the seat map and return the result word it should produce.
   function automatic result_type predict_allocation(input request_type r);
      result_type  res;
      int unsigned z, cap, run, idx, col;
      bit          hit;
      res = '{ST_BAD, '0, '0};
      if (r.zone != ZONE_NONE) begin
         z   = r.zone;
         cap = zone_rows(r.zone) * SLOTS;
         hit = 1'b0;
         if (r.seat_count == 0) begin
            res.status = ST_BAD;
         end else if (r.action == ACT_RESERVE) begin
            if (r.owner_id == 0) begin
               res.status = ST_BAD;
            end else if (seats_free[z] < r.seat_count) begin
               res.status = ST_FEW;
            end else begin
               res.status = ST_NORUN;
               for (int row = 0; row < zone_rows(r.zone) && !hit; row++) begin
                  run = 0;
                  for (int c = 0; c < SLOTS && !hit; c++) begin
                     idx = row * SLOTS + c;
                     run = (seat_owner[z][idx] == 0) ? run + 1 : 0;
                     if (run == r.seat_count) begin
                        hit = 1'b1;
                        res.start_seat = SEAT_W'(idx + 1 - r.seat_count);
                     end
                  end
               end
               if (hit) begin
                  for (int k = 0; k < r.seat_count; k++)
                     seat_owner[z][res.start_seat + k] = r.owner_id;
                  seats_free[z] -= r.seat_count;
                  res.status = ST_DONE;
               end
            end
         end else begin
            col = r.first_seat % SLOTS;
            if (r.first_seat + r.seat_count > cap || col + r.seat_count > SLOTS) begin
               res.status = ST_BAD;
            end else begin
               for (int k = 0; k < r.seat_count; k++)
                  seat_owner[z][r.first_seat + k] = '0;
               seats_free[z] = (seats_free[z] + r.seat_count > cap) ?
                               cap : seats_free[z] + r.seat_count;
               res.status = ST_DONE;
            end
         end
         res.free_after = FREE_OUT_W'(seats_free[z]);
      end
      return res;
   endfunction

   function automatic logic [COUNT_W-1:0] random_length();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6)
         return '0;
      else if (pick < 12)
         return COUNT_W'($urandom_range(31, 17));
      else if (pick < 24)
         return COUNT_W'($urandom_range(16, 9));
      else
         return COUNT_W'($urandom_range(8, 1));
   endfunction

   // Mostly well-formed traffic: reserves with live owners, releases of runs still held.
   function automatic request_type random_request(input int reserve_pct);
      request_type  r;
      held_run_type h;
      int           pick;
      r.action     = ($urandom_range(99) < reserve_pct) ? ACT_RESERVE : ACT_RELEASE;
      r.zone       = ($urandom_range(19) == 0) ? ZONE_NONE : ZONE_W'($urandom_range(2));
      r.seat_count = random_length();
      r.owner_id   = ($urandom_range(24) == 0) ? '0 :
                     OWNER_IN_W'($urandom_range(16'hFFFF, 1));
      r.first_seat = SEAT_W'($urandom_range(127));
      if (r.action == ACT_RELEASE) begin
         if (held_runs.size() != 0 && $urandom_range(99) < 55) begin
            pick = $urandom_range(held_runs.size() - 1);
            h = held_runs[pick];
            held_runs.delete(pick);
            r.zone       = h.zone;
            r.first_seat = h.start;
            r.seat_count = h.count;
         end else if (r.seat_count != 0 && r.seat_count <= SLOTS &&
                      $urandom_range(99) < 70) begin
            r.first_seat = SEAT_W'($urandom_range(ROWS_A - 1) * SLOTS +
                                   $urandom_range(SLOTS - r.seat_count));
         end
      end
      return r;
   endfunction

   task automatic log_mismatch(input string field, input int got, input int want);
      $display("[%0t] result %0d: %s got %0d, want %0d", $realtime, results_seen, field,
               got, want);
      mismatches++;
   endtask

   // Present one word, hold it until taken, then record what it should return.
   task automatic issue_request(input request_type r, input bit typed, input result_type want);
      result_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.action;
      req_tdata  <= {2'b00, r.first_seat, r.owner_id, r.seat_count, r.zone};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pred = predict_allocation(r);
      expected_results.push_back(typed ? want : pred);
      if (r.action == ACT_RESERVE && pred.status == ST_DONE)
         held_runs.push_back('{r.zone, pred.start_seat, r.seat_count});
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            log_mismatch("unexpected word", int'(rsp_tdata), -1);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               log_mismatch("status", int'(rsp_tdata[1:0]), int'(want.status));
            if (rsp_tdata[8:2] !== want.start_seat)
               log_mismatch("start_seat", int'(rsp_tdata[8:2]), int'(want.start_seat));
            if (rsp_tdata[16:9] !== want.free_after)
               log_mismatch("free_after", int'(rsp_tdata[16:9]), int'(want.free_after));
            if (rsp_tdata[RSP_DATA_W-1:17] !== '0)
               log_mismatch("pad bits", int'(rsp_tdata[RSP_DATA_W-1:17]), 0);
         end
         results_seen++;
      end
   end

   // Stop a hung run: count cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int reserve_pct;
      for (int z = 0; z < 3; z++) begin
         seats_free[z] = zone_rows(ZONE_W'(z)) * SLOTS;
         for (int s = 0; s < ROWS_A * SLOTS; s++)
            seat_owner[z][s] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         issue_request(script[i].req, script[i].typed, script[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // shift between filling and draining so zones run near full and near empty
         case ((n / 100) % 6)
            0:       reserve_pct = 75;
            1:       reserve_pct = 85;
            2:       reserve_pct = 35;
            3:       reserve_pct = 90;
            4:       reserve_pct = 25;
            default: reserve_pct = 60;
         endcase
         req_idle_pct = (n >= 250 && n < 380) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         issue_request(random_request(reserve_pct), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### contiguous_run_allocator_core.f
hdl/cra_pkg.sv
hdl/cra_ram.sv
hdl/cra_run_find.sv
hdl/contiguous_run_allocator_core.sv
tb/tb.sv
